/* hdl/egrr_pkg.sv */
// Shared types and constants for the epoch-gated reclaim ring.
package egrr_pkg;

  localparam int unsigned HANDLE_W  = 48;
  localparam int unsigned EPOCH_W   = 32;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned BUMPS_W   = 3;
  localparam int unsigned ENTRY_W   = EPOCH_W + 3 * HANDLE_W;
  localparam logic [BUMPS_W-1:0] FULL_BUMPS = 3'd4;

  // One push item
  typedef struct packed {
    logic [HANDLE_W-1:0] item_handle;
    logic [HANDLE_W-1:0] release_tag;
    logic [HANDLE_W-1:0] release_context;
    logic [EPOCH_W-1:0]  current_epoch;
    logic [EPOCH_W-1:0]  safe_epoch;
  } push_item_t;

  // One result item
  typedef struct packed {
    logic                freed_valid;
    logic [HANDLE_W-1:0] freed_handle;
    logic [HANDLE_W-1:0] freed_tag;
    logic [HANDLE_W-1:0] freed_context;
    logic [SLOT_W-1:0]   slot_used;
    logic                ring_full;
    logic [BUMPS_W-1:0]  epoch_bumps;
  } result_item_t;

  // Stored ring entry
  typedef struct packed {
    logic [EPOCH_W-1:0]  epoch;
    logic [HANDLE_W-1:0] handle;
    logic [HANDLE_W-1:0] tag;
    logic [HANDLE_W-1:0] context_word;
  } entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // latch push item, read slot at pointer
    logic step;    // slot skipped, read following slot
    logic finish;  // store if reclaimable, load result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic reclaim;   // slot under test can take the new entry
    logic last_try;  // slot under test is the last of the walk
    logic out_busy;  // result register full and stalled
  } dp_status_t;

endpackage

/* hdl/epoch_gated_reclaim_ring.sv */
// A push is taken while idle; its result is registered once the walk over the
// entry RAM's registered read port finds a reclaimable slot or reaches the
// last slot. Each skipped occupied slot adds a read. No new push is taken
// until that result is loaded, which also waits while the result stalls.
// Reset: slot pointer to the last slot, fill count to zero (ring reads empty),
// no clearing pass; pushes are taken as soon as reset is released.
module epoch_gated_reclaim_ring #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_stall,
  input  egrr_pkg::push_item_t   push_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output egrr_pkg::result_item_t result_data
);
  import egrr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  egrr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .status     (status),
    .cmd        (cmd)
  );

  egrr_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .push_data    (push_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

/* hdl/egrr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module egrr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/egrr_ctrl.sv */
// Controller: sequences the slot walk of one push item.
module egrr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_stall,
  input  egrr_pkg::dp_status_t status,
  output egrr_pkg::ctrl_cmd_t  cmd
);
  import egrr_pkg::*;

  state_t state, state_next;
  logic   done;

  assign done = status.reclaim || status.last_try;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (push_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (done && !status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    push_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        push_stall = rst;
        cmd.accept = push_valid && !rst;
      end
      ST_CHECK: begin
        // hold the finishing try while the result register is stalled
        cmd.step   = !done;
        cmd.finish = done && !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* hdl/egrr_dpath.sv */
// Datapath: slot pointer, fill count, entry RAM, reclaim test, result register.
module egrr_dpath #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  egrr_pkg::push_item_t   push_data,
  input  egrr_pkg::ctrl_cmd_t    cmd,
  output egrr_pkg::dp_status_t   status,
  output logic                   result_valid,
  input  logic                   result_stall,
  output egrr_pkg::result_item_t result_data
);
  import egrr_pkg::*;

  localparam int unsigned SW      = $clog2(SLOTS);
  localparam int unsigned CW      = SW + 1;
  localparam int unsigned QUARTER = SLOTS / 4;

  push_item_t        item;
  logic [SW-1:0]     slot_ptr;
  logic [SW-1:0]     slot_inc;
  logic [SW-1:0]     tries;
  logic [CW-1:0]     fill;
  logic [BUMPS_W-1:0] bumps;
  logic [BUMPS_W-1:0] bumps_total;
  logic              bump;
  logic              seen;
  logic              occupied;
  logic              reclaim;
  logic              re;
  logic [SW-1:0]     raddr;
  entry_t            rd_entry;
  entry_t            wr_entry;
  result_item_t      res;

  assign slot_inc = slot_ptr + 1'b1;

  // Entry store
  assign re    = cmd.accept || cmd.step;
  assign raddr = cmd.accept ? slot_ptr : slot_inc;

  assign wr_entry.epoch        = item.current_epoch;
  assign wr_entry.handle       = item.item_handle;
  assign wr_entry.tag          = item.release_tag;
  assign wr_entry.context_word = item.release_context;

  egrr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.finish && reclaim),
    .waddr (slot_ptr),
    .wdata (wr_entry),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  // Slots are first visited in ring order from the reset pointer, so a slot
  // holds data only if its visit order is below the count of tries so far.
  assign seen     = {1'b0, slot_inc} < fill;
  assign occupied = seen && (rd_entry.epoch != '0);
  assign reclaim  = !occupied || (rd_entry.epoch <= item.safe_epoch);

  // Quarter-ring boundary on the slot under test
  assign bump        = (slot_ptr & SW'(QUARTER - 1)) == '0;
  assign bumps_total = bumps + BUMPS_W'(bump);

  assign status.reclaim  = reclaim;
  assign status.last_try = tries == SW'(SLOTS - 1);
  assign status.out_busy = result_valid && result_stall;

  // Walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ptr <= SW'(SLOTS - 1);
      fill     <= '0;
    end else if (cmd.step || cmd.finish) begin
      slot_ptr <= slot_inc;
      if (fill != CW'(SLOTS)) fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item  <= push_data;
      tries <= '0;
      bumps <= '0;
    end else if (cmd.step) begin
      tries <= tries + 1'b1;
      bumps <= bumps_total;
    end
  end

  // Result of the finishing try
  always_comb begin
    res               = '0;
    res.ring_full     = !reclaim;
    res.epoch_bumps   = bumps_total;
    if (reclaim) begin
      res.slot_used = SLOT_W'(slot_ptr);
      if (occupied) begin
        res.freed_valid   = 1'b1;
        res.freed_handle  = rd_entry.handle;
        res.freed_tag     = rd_entry.tag;
        res.freed_context = rd_entry.context_word;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result_data <= res;
    end
  end

endmodule

/* hdl/egrr_checker.sv */
// Port-level checks for the reclaim ring, bound to the top level.
module egrr_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   push_valid,
  input logic                   push_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input egrr_pkg::result_item_t result_data
);
  import egrr_pkg::*;

  logic [1:0] outstanding;
  logic       push_acc;
  logic       result_acc;

  assign push_acc   = push_valid && !push_stall;
  assign result_acc = result_valid && !result_stall;

  // Items taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 2'(push_acc) - 2'(result_acc);
    end
  end

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("stalled result changed");

  // Every result answers an accepted push
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> outstanding != 2'd0)
    else $error("result without a pending push");

  // A full ring walks all four quarters and frees nothing
  a_full_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.ring_full |->
      result_data.epoch_bumps == FULL_BUMPS && !result_data.freed_valid &&
      result_data.slot_used == '0)
    else $error("bad full-ring result");

  // Nothing freed means zero freed fields
  a_freed_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.freed_valid |->
      result_data.freed_handle == '0 && result_data.freed_tag == '0 &&
      result_data.freed_context == '0)
    else $error("freed fields set without a release");

endmodule

bind epoch_gated_reclaim_ring egrr_checker u_egrr_checker (.*);

/* sim/epoch_gated_reclaim_ring_tb.sv */
// Testbench for the epoch-gated reclaim ring: random pushes checked against a ring predictor.
`timescale 1ns / 1ps

module epoch_gated_reclaim_ring_tb;
  import egrr_pkg::*;

  localparam int RING_SLOTS     = 1 << SLOT_W;
  localparam int QUARTER        = RING_SLOTS / 4;
  localparam int DIRECTED_ITEMS = 19;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int DRAIN_AT       = 700;   // sender waits for all results after this item
  localparam int HOLDOFF_AT     = 300;   // receiver holds off once this many results came
  localparam int HOLDOFF_CYCLES = 400;
  localparam int STUCK_LIMIT    = 3000;

  typedef enum int {
    RUN_STEADY,
    RUN_FILL,
    RUN_FLUSH,
    RUN_NOISE
  } run_kind_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         push_valid = 1'b0;
  logic         push_stall;
  push_item_t   push_data = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result_data;

  epoch_gated_reclaim_ring dut (
    .clk          (clk),
    .rst          (rst),
    .push_valid   (push_valid),
    .push_stall   (push_stall),
    .push_data    (push_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  always #5 clk = ~clk;

  // Stimulus and expectations
  push_item_t   push_backlog[$];
  result_item_t reclaim_expect[$];

  // Predictor copy of the ring
  entry_t            ring_entry [RING_SLOTS];
  logic [SLOT_W-1:0] ring_cursor;

  logic [EPOCH_W-1:0] epoch_now;
  int pushes_taken  = 0;
  int results_taken = 0;
  int mismatches    = 0;
  int stuck_cycles  = 0;

  // Sender state
  int   offered    = 0;
  int   burst_left = 1;
  int   gap_left   = 0;
  logic drain_hold = 1'b0;
  logic drain_done = 1'b0;

  // Receiver state
  int   holdoff_left = 0;
  logic holdoff_done = 1'b0;
  int   stall_mode   = 0;
  int   pattern_left = 0;

  // Walk the ring from the cursor and place the new entry; returns the result item
  function automatic result_item_t reclaim_walk(input push_item_t p);
    result_item_t      r;
    logic [SLOT_W-1:0] s;
    entry_t            old;
    logic              placed;
    r = '0;
    r.ring_full = 1'b1;
    placed = 1'b0;
    for (int n = 0; n < RING_SLOTS; n++) begin
      if (!placed) begin
        s = ring_cursor;
        ring_cursor = ring_cursor + 1'b1;
        if (s % QUARTER == 0) r.epoch_bumps = r.epoch_bumps + 1'b1;
        old = ring_entry[s];
        // epoch zero reads as empty; otherwise reclaim only at or below the safe epoch
        if (old.epoch == '0 || old.epoch <= p.safe_epoch) begin
          if (old.epoch != '0) begin
            r.freed_valid   = 1'b1;
            r.freed_handle  = old.handle;
            r.freed_tag     = old.tag;
            r.freed_context = old.context_word;
          end
          ring_entry[s] = {p.current_epoch, p.item_handle, p.release_tag, p.release_context};
          r.slot_used = s;
          r.ring_full = 1'b0;
          placed = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [HANDLE_W-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: w = '0;
      1: w = '1;
      default: ;
    endcase
    return w[HANDLE_W-1:0];
  endfunction

  task automatic queue_push(input logic [HANDLE_W-1:0] h, input logic [HANDLE_W-1:0] t,
                            input logic [HANDLE_W-1:0] c, input logic [EPOCH_W-1:0] cur,
                            input logic [EPOCH_W-1:0] safe);
    push_item_t p;
    p.item_handle     = h;
    p.release_tag     = t;
    p.release_context = c;
    p.current_epoch   = cur;
    p.safe_epoch      = safe;
    push_backlog.push_back(p);
  endtask

  // One run of pushes with a common epoch pattern
  task automatic queue_run(input run_kind_t kind, input int count);
    logic [EPOCH_W-1:0] cur;
    logic [EPOCH_W-1:0] safe;
    for (int n = 0; n < count; n++) begin
      case (kind)
        RUN_STEADY: begin
          // epoch advances slowly, readers lag a little, sometimes a lot
          if ($urandom_range(0, 2) == 0) epoch_now = epoch_now + 1;
          cur = epoch_now;
          if ($urandom_range(0, 7) == 0) safe = epoch_now - $urandom_range(0, 60);
          else safe = epoch_now - $urandom_range(0, 4);
        end
        RUN_FILL: begin
          // nothing releasable: fills the empty slots, then the ring reports full
          cur  = epoch_now;
          safe = '0;
        end
        RUN_FLUSH: begin
          cur  = epoch_now;
          safe = '1;
        end
        default: begin
          cur = $urandom;
          if (cur == '0) cur = 1;
          safe = $urandom;
        end
      endcase
      queue_push(rand_word(), rand_word(), rand_word(), cur, safe);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s at result %0d: expected %0h, got %0h",
               what, results_taken, want, got);
  endtask

  // Push driver: bursts with gaps, one pause until everything is back
  always @(posedge clk) begin : push_driver
    logic go;
    if (rst) begin
      push_valid <= 1'b0;
    end else if (!push_valid || !push_stall) begin
      go = 1'b0;
      if (drain_hold) begin
        if (pushes_taken == results_taken) drain_hold = 1'b0;
      end else if (offered == DRAIN_AT && !drain_done) begin
        drain_hold = 1'b1;
        drain_done = 1'b1;
      end else if (gap_left != 0) begin
        gap_left = gap_left - 1;
      end else if (push_backlog.size() != 0) begin
        go = 1'b1;
        push_data <= push_backlog.pop_front();
        offered++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left = burst_left - 1;
        end
      end
      push_valid <= go;
    end
  end

  // Monitor: predict on accepted pushes, check accepted results, drive the stall
  always @(posedge clk) begin : result_monitor
    result_item_t want;
    logic         stall_next;
    if (rst) begin
      result_stall  <= 1'b0;
      pushes_taken  <= 0;
      results_taken <= 0;
      ring_cursor = SLOT_W'(RING_SLOTS - 1);
      for (int i = 0; i < RING_SLOTS; i++) ring_entry[i] = '0;
    end else begin
      // check results first so a same-edge push cannot be taken for them
      if (result_valid && !result_stall) begin
        results_taken <= results_taken + 1;
        if (reclaim_expect.size() == 0) begin
          note_mismatch("unexpected result", '0, 64'(result_data.slot_used));
        end else begin
          want = reclaim_expect.pop_front();
          if (result_data.freed_valid !== want.freed_valid)
            note_mismatch("freed_valid", 64'(want.freed_valid),
                          64'(result_data.freed_valid));
          if (result_data.freed_handle !== want.freed_handle)
            note_mismatch("freed_handle", 64'(want.freed_handle),
                          64'(result_data.freed_handle));
          if (result_data.freed_tag !== want.freed_tag)
            note_mismatch("freed_tag", 64'(want.freed_tag), 64'(result_data.freed_tag));
          if (result_data.freed_context !== want.freed_context)
            note_mismatch("freed_context", 64'(want.freed_context),
                          64'(result_data.freed_context));
          if (result_data.slot_used !== want.slot_used)
            note_mismatch("slot_used", 64'(want.slot_used), 64'(result_data.slot_used));
          if (result_data.ring_full !== want.ring_full)
            note_mismatch("ring_full", 64'(want.ring_full), 64'(result_data.ring_full));
          if (result_data.epoch_bumps !== want.epoch_bumps)
            note_mismatch("epoch_bumps", 64'(want.epoch_bumps),
                          64'(result_data.epoch_bumps));
        end
      end
      if (push_valid && !push_stall) begin
        pushes_taken <= pushes_taken + 1;
        reclaim_expect.push_back(reclaim_walk(push_data));
      end

      // stall: one long hold-off, otherwise a pattern that changes every so often
      stall_next = 1'b0;
      if (holdoff_left != 0) begin
        holdoff_left = holdoff_left - 1;
        stall_next = 1'b1;
      end else begin
        if (!holdoff_done && results_taken >= HOLDOFF_AT) begin
          holdoff_done = 1'b1;
          holdoff_left = HOLDOFF_CYCLES;
        end
        if (pattern_left == 0) begin
          stall_mode   = $urandom_range(0, 3);
          pattern_left = $urandom_range(20, 200);
        end else begin
          pattern_left = pattern_left - 1;
        end
        case (stall_mode)
          0: stall_next = 1'b0;
          1: stall_next = ($urandom_range(0, 3) == 0);
          2: stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = ~result_stall;
        endcase
        if (holdoff_left != 0) stall_next = 1'b1;
      end
      result_stall <= stall_next;
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (push_valid && !push_stall) || (result_valid && !result_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Stimulus, reset and end of run
  initial begin
    epoch_now = 32'd100;

    // field extremes, zero epoch, a walk across the first quarter boundary
    queue_push('1, '1, '1, 32'd1, '0);
    queue_push('0, '0, '0, '1, '1);
    queue_push(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, '0, '0);
    queue_push(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
               32'h8000_0000, 32'h7FFF_FFFF);
    for (int n = 0; n < 15; n++)
      queue_push(rand_word(), rand_word(), rand_word(), epoch_now + n, '0);

    // fill to full early, then eight pushes that can release any entry
    queue_run(RUN_FILL, 70);
    queue_run(RUN_FLUSH, 8);
    while (push_backlog.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2:    queue_run(RUN_FILL, $urandom_range(10, 70));
        3, 4, 5:    queue_run(RUN_FLUSH, $urandom_range(3, 20));
        6, 7:       queue_run(RUN_NOISE, $urandom_range(3, 20));
        default:    queue_run(RUN_STEADY, $urandom_range(20, 80));
      endcase
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (push_backlog.size() != 0 || push_valid) @(posedge clk);
    while (results_taken != pushes_taken) @(posedge clk);
    repeat (RING_SLOTS + 16) @(posedge clk);
    if (mismatches == 0 && reclaim_expect.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
